/* sv/assert_macros.svh */
// Assertion macros used by the microcode sequencer of the I2C bit sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked property check with asynchronous reset gating
`define CHK_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Plain invariant checked at every rising clock edge outside reset
`define CHK_HOLD(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

`else

`define CHK_PROP(lbl, clk, rstn, prop, msg)
`define CHK_HOLD(lbl, clk, rstn, expr, msg)

`endif

`endif

/* sv/i2cbs_pkg.sv */
// Package for the I2C bit sequencer: opcodes, control word type and microcode ROM.
package i2cbs_pkg;

    // Command opcodes
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_STOP     = 3'd1;
    localparam logic [2:0] OP_WRITE    = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_SEND_ACK = 3'd4;
    localparam logic [2:0] OP_RECV_ACK = 3'd5;

    localparam int BYTE_BITS = 8;
    localparam int CNT_W     = $clog2(BYTE_BITS);
    localparam int PROG_LEN  = 19;
    localparam int PC_W      = $clog2(PROG_LEN);

    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(BYTE_BITS - 1);

    // Pin value source
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_ONE  = 2'd1;
    localparam logic [1:0] SRC_TX   = 2'd2;
    localparam logic [1:0] SRC_ACK  = 2'd3;

    // Result payload selection on the final write
    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_BYTE = 2'd1;
    localparam logic [1:0] RES_ACK  = 2'd2;

    // Program entry points
    localparam logic [PC_W-1:0] PC_START = PC_W'(0);
    localparam logic [PC_W-1:0] PC_STOP  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_WRITE = PC_W'(7);
    localparam logic [PC_W-1:0] PC_READ  = PC_W'(10);
    localparam logic [PC_W-1:0] PC_RDLP  = PC_W'(11);
    localparam logic [PC_W-1:0] PC_SACK  = PC_W'(13);
    localparam logic [PC_W-1:0] PC_RACK  = PC_W'(16);

    // One microcode word
    typedef struct packed {
        logic            pin_scl;  // 1 writes SCL, 0 writes SDA
        logic [1:0]      src;
        logic            sample;
        logic            jmp;      // loop back while bits remain
        logic            fin;      // command ends here when no loop is taken
        logic [1:0]      res_sel;
        logic [PC_W-1:0] target;
    } ucw_t;

    // Control handed from sequencer to datapath for one step
    typedef struct packed {
        logic en;
        logic last;
        ucw_t cw;
    } step_t;

    function automatic ucw_t mk(logic scl, logic [1:0] src, logic smp, logic jmp,
                                logic fin, logic [1:0] res, logic [PC_W-1:0] tgt);
        ucw_t w;
        w.pin_scl = scl;
        w.src     = src;
        w.sample  = smp;
        w.jmp     = jmp;
        w.fin     = fin;
        w.res_sel = res;
        w.target  = tgt;
        return w;
    endfunction

    // Microcode ROM
    function automatic ucw_t ucode_rom(logic [PC_W-1:0] a);
        ucw_t w;
        unique case (a)
            // start
            PC_W'(0):  w = mk(1'b0, SRC_ONE,  1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(1):  w = mk(1'b1, SRC_ONE,  1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(2):  w = mk(1'b0, SRC_ZERO, 1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(3):  w = mk(1'b1, SRC_ZERO, 1'b0, 1'b0, 1'b1, RES_NONE, PC_START);
            // stop
            PC_W'(4):  w = mk(1'b0, SRC_ZERO, 1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(5):  w = mk(1'b1, SRC_ONE,  1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(6):  w = mk(1'b0, SRC_ONE,  1'b0, 1'b0, 1'b1, RES_NONE, PC_START);
            // write byte
            PC_W'(7):  w = mk(1'b0, SRC_TX,   1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(8):  w = mk(1'b1, SRC_ONE,  1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(9):  w = mk(1'b1, SRC_ZERO, 1'b0, 1'b1, 1'b1, RES_NONE, PC_WRITE);
            // read byte
            PC_W'(10): w = mk(1'b0, SRC_ONE,  1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(11): w = mk(1'b1, SRC_ONE,  1'b1, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(12): w = mk(1'b1, SRC_ZERO, 1'b0, 1'b1, 1'b1, RES_BYTE, PC_RDLP);
            // send ack
            PC_W'(13): w = mk(1'b0, SRC_ACK,  1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(14): w = mk(1'b1, SRC_ONE,  1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(15): w = mk(1'b1, SRC_ZERO, 1'b0, 1'b0, 1'b1, RES_NONE, PC_START);
            // receive ack
            PC_W'(16): w = mk(1'b0, SRC_ONE,  1'b0, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(17): w = mk(1'b1, SRC_ONE,  1'b1, 1'b0, 1'b0, RES_NONE, PC_START);
            PC_W'(18): w = mk(1'b1, SRC_ZERO, 1'b0, 1'b0, 1'b1, RES_ACK,  PC_START);
            default:   w = mk(1'b0, SRC_ONE,  1'b0, 1'b0, 1'b1, RES_NONE, PC_START);
        endcase
        return w;
    endfunction

    // Entry address of each command
    function automatic logic [PC_W-1:0] op_entry(logic [2:0] op);
        logic [PC_W-1:0] e;
        unique case (op)
            OP_START:    e = PC_START;
            OP_STOP:     e = PC_STOP;
            OP_WRITE:    e = PC_WRITE;
            OP_READ:     e = PC_READ;
            OP_SEND_ACK: e = PC_SACK;
            OP_RECV_ACK: e = PC_RACK;
            default:     e = PC_START;
        endcase
        return e;
    endfunction

endpackage

/* sv/i2c_master_bit_sequencer.sv */
// I2C master bit sequencer top level.
//
// Input channel (in_valid/in_ready) takes one bus command per transaction:
// start, stop, write byte, read byte, send ack or receive ack, with the
// byte to send, the ack level and the slave line levels alongside.
// Output channel (out_valid/out_ready) gives one transaction per pin write,
// carrying SCL and SDA levels, a sample flag and a last flag; the final
// write of read byte carries rx_byte, of receive ack carries ack_seen.
// A command is run by a microcode program: one ROM word per pin write, with
// a loop counter for the eight bit slots. The sequencer steps one result
// per cycle while the output register is free to take it.
// Opcodes 6 and 7 are accepted and produce nothing.
// A stalled receiver holds the result register and freezes the program;
// the next command is accepted while the final result still waits.
// Reset releases both lines high and empties the output register.
module i2c_master_bit_sequencer
    import i2cbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] opcode,
    input  logic [7:0] tx_byte,
    input  logic       ack_level,
    input  logic [7:0] line_bits,
    input  logic       line_ack,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sample_now,
    output logic       last_event,
    output logic [7:0] rx_byte,
    output logic       ack_seen
);

    step_t step;
    logic  out_free;
    logic  load;

    assign load = in_valid && in_ready;

    i2cbs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .out_free (out_free),
        .step     (step)
    );

    i2cbs_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .opcode     (opcode),
        .tx_byte    (tx_byte),
        .ack_level  (ack_level),
        .line_bits  (line_bits),
        .line_ack   (line_ack),
        .step       (step),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .sample_now (sample_now),
        .last_event (last_event),
        .rx_byte    (rx_byte),
        .ack_seen   (ack_seen)
    );

endmodule

/* sv/i2cbs_seq.sv */
// Microcode sequencer: program counter, bit loop counter and ROM fetch.
`include "assert_macros.svh"

module i2cbs_seq
    import i2cbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] opcode,
    input  logic       out_free,
    output step_t      step
);

    logic             busy_reg, busy_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             op_ok;
    logic             loop_taken;
    ucw_t             cw;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign op_ok    = (opcode <= OP_RECV_ACK);

    // Fetch and decode the current step
    assign cw         = ucode_rom(pc_reg);
    assign step.en    = busy_reg && out_free;
    assign step.cw    = cw;
    assign loop_taken = cw.jmp && (cnt_reg != '0);
    assign step.last  = cw.fin && !loop_taken;

    // Next program state
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            busy_next = op_ok;
            pc_next   = op_entry(opcode);
            cnt_next  = CNT_LOAD;
        end
        else if (step.en)
        begin
            if (loop_taken)
            begin
                pc_next  = cw.target;
                cnt_next = cnt_reg - 1'b1;
            end
            else if (cw.fin)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_START;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
        end
    end

    `CHK_HOLD(a_pc_range, clk, rst_n, !busy_reg || (pc_reg < PC_W'(PROG_LEN)), "pc out of program")
    `CHK_PROP(a_start_busy, clk, rst_n, accept && op_ok |=> busy_reg, "valid command did not start")
    `CHK_PROP(a_last_idle, clk, rst_n, step.en && step.last |=> !busy_reg, "busy after last step")
    `CHK_PROP(a_loop_dec, clk, rst_n, step.en && loop_taken |=> cnt_reg == $past(cnt_reg) - 1'b1, "bit count not stepped")

endmodule

/* sv/i2cbs_dpath.sv */
// Datapath: pin state, shift registers and the result output register.
module i2cbs_dpath
    import i2cbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [2:0] opcode,
    input  logic [7:0] tx_byte,
    input  logic       ack_level,
    input  logic [7:0] line_bits,
    input  logic       line_ack,
    input  step_t      step,
    output logic       out_free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sample_now,
    output logic       last_event,
    output logic [7:0] rx_byte,
    output logic       ack_seen
);

    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic [7:0] tx_sh_reg, tx_sh_next;
    logic [7:0] line_sh_reg, line_sh_next;
    logic [7:0] rx_sh_reg, rx_sh_next;
    logic       ackl_reg, ackl_next;
    logic       ov_reg, ov_next;
    logic       pin_val;

    logic       o_scl_reg, o_sda_reg, o_smp_reg, o_last_reg, o_ack_reg;
    logic [7:0] o_rx_reg;

    assign out_free  = !ov_reg || out_ready;
    assign out_valid = ov_reg;

    // Value written to the selected pin
    always_comb
    begin
        unique case (step.cw.src)
            SRC_ZERO: pin_val = 1'b0;
            SRC_ONE:  pin_val = 1'b1;
            SRC_TX:   pin_val = tx_sh_reg[7];
            SRC_ACK:  pin_val = ackl_reg;
            default:  pin_val = 1'b1;
        endcase
    end

    // Pin and shift register updates
    always_comb
    begin
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        tx_sh_next   = tx_sh_reg;
        line_sh_next = line_sh_reg;
        rx_sh_next   = rx_sh_reg;
        ackl_next    = ackl_reg;
        if (load)
        begin
            tx_sh_next   = tx_byte;
            line_sh_next = (opcode == OP_READ) ? line_bits : {line_ack, 7'd0};
            ackl_next    = ack_level;
        end
        else if (step.en)
        begin
            if (step.cw.pin_scl)
                scl_next = pin_val;
            else
                sda_next = pin_val;
            if (step.cw.src == SRC_TX)
                tx_sh_next = {tx_sh_reg[6:0], 1'b0};
            if (step.cw.sample)
            begin
                rx_sh_next   = {rx_sh_reg[6:0], line_sh_reg[7]};
                line_sh_next = {line_sh_reg[6:0], 1'b0};
            end
        end
    end

    // Output valid tracking
    always_comb
    begin
        ov_next = ov_reg;
        if (step.en)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            ov_reg  <= 1'b0;
        end
        else
        begin
            scl_reg <= scl_next;
            sda_reg <= sda_next;
            ov_reg  <= ov_next;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        tx_sh_reg   <= tx_sh_next;
        line_sh_reg <= line_sh_next;
        rx_sh_reg   <= rx_sh_next;
        ackl_reg    <= ackl_next;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (step.en)
        begin
            o_scl_reg  <= scl_next;
            o_sda_reg  <= sda_next;
            o_smp_reg  <= step.cw.sample;
            o_last_reg <= step.last;
            o_rx_reg   <= (step.last && step.cw.res_sel == RES_BYTE) ? rx_sh_reg : 8'd0;
            o_ack_reg  <= step.last && (step.cw.res_sel == RES_ACK) && rx_sh_reg[0];
        end
    end

    assign scl_level  = o_scl_reg;
    assign sda_level  = o_sda_reg;
    assign sample_now = o_smp_reg;
    assign last_event = o_last_reg;
    assign rx_byte    = o_rx_reg;
    assign ack_seen   = o_ack_reg;

endmodule

/* bench/i2c_master_bit_sequencer_tb.sv */
// Self-checking testbench for the I2C master bit sequencer: random command streams vs. a predictor.
module i2c_master_bit_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbs_pkg::*;

    // Opcodes the block accepts and drops
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam int TARGET_CMDS    = 260;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_CMD    = 100;
    localparam int QUIET_FROM_CMD = 220;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;

    // One expected pin write
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       smp;
        logic       last;
        logic [7:0] rx;
        logic       ack;
    } pin_write_t;

    // Bus-level predictor and store of expected pin writes
    class pin_write_scoreboard;
        pin_write_t pending_writes[$];
        bit         scl_line = 1'b1;
        bit         sda_line = 1'b1;
        int         mismatches = 0;
        int         writes_checked = 0;

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void push_write(bit smp);
            pin_write_t w;
            w = '0;
            w.scl = scl_line;
            w.sda = sda_line;
            w.smp = smp;
            pending_writes.push_back(w);
        endfunction

        function void drive_sda(bit v);
            sda_line = v;
            push_write(1'b0);
        endfunction

        function void drive_scl(bit v, bit smp);
            scl_line = v;
            push_write(smp);
        endfunction

        // Expand one accepted command into its pin writes
        function void expand_command(logic [2:0] op, logic [7:0] tx, logic al,
                                     logic [7:0] lb, logic la);
            pin_write_t w;
            case (op)
                OP_START:
                begin
                    drive_sda(1'b1);
                    drive_scl(1'b1, 1'b0);
                    drive_sda(1'b0);
                    drive_scl(1'b0, 1'b0);
                end
                OP_STOP:
                begin
                    drive_sda(1'b0);
                    drive_scl(1'b1, 1'b0);
                    drive_sda(1'b1);
                end
                OP_WRITE:
                begin
                    for (int b = 7; b >= 0; b--)
                    begin
                        drive_sda(tx[b]);
                        drive_scl(1'b1, 1'b0);
                        drive_scl(1'b0, 1'b0);
                    end
                end
                OP_READ:
                begin
                    drive_sda(1'b1);
                    for (int b = 0; b < BYTE_BITS; b++)
                    begin
                        drive_scl(1'b1, 1'b1);
                        drive_scl(1'b0, 1'b0);
                    end
                end
                OP_SEND_ACK:
                begin
                    drive_sda(al);
                    drive_scl(1'b1, 1'b0);
                    drive_scl(1'b0, 1'b0);
                end
                OP_RECV_ACK:
                begin
                    drive_sda(1'b1);
                    drive_scl(1'b1, 1'b1);
                    drive_scl(1'b0, 1'b0);
                end
                default:
                    return;
            endcase
            // final write of the command carries the flag and any received data
            w = pending_writes.pop_back();
            w.last = 1'b1;
            if (op == OP_READ)
                w.rx = lb;
            if (op == OP_RECV_ACK)
                w.ack = la;
            pending_writes.push_back(w);
        endfunction

        // Compare one accepted pin write against the oldest expectation
        task check_pin_write(logic scl, logic sda, logic smp, logic last,
                             logic [7:0] rx, logic ack);
            pin_write_t w;
            if (pending_writes.size() == 0)
            begin
                report("pin write with nothing expected");
                return;
            end
            w = pending_writes.pop_front();
            if (scl !== w.scl)
                report($sformatf("write %0d scl_level got %b exp %b", writes_checked, scl, w.scl));
            if (sda !== w.sda)
                report($sformatf("write %0d sda_level got %b exp %b", writes_checked, sda, w.sda));
            if (smp !== w.smp)
                report($sformatf("write %0d sample_now got %b exp %b", writes_checked, smp, w.smp));
            if (last !== w.last)
                report($sformatf("write %0d last_event got %b exp %b", writes_checked, last, w.last));
            if (rx !== w.rx)
                report($sformatf("write %0d rx_byte got %h exp %h", writes_checked, rx, w.rx));
            if (ack !== w.ack)
                report($sformatf("write %0d ack_seen got %b exp %b", writes_checked, ack, w.ack));
            writes_checked++;
        endtask
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] opcode = OP_START;
    logic [7:0] tx_byte = 8'h00;
    logic       ack_level = 1'b0;
    logic [7:0] line_bits = 8'h00;
    logic       line_ack = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       scl_level;
    logic       sda_level;
    logic       sample_now;
    logic       last_event;
    logic [7:0] rx_byte;
    logic       ack_seen;

    pin_write_scoreboard sb = new();

    int  sent_cmds = 0;
    int  ignored_cmds = 0;
    int  transfers = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_idles = 1'b1;
    bit  long_hold_done = 1'b0;

    i2c_master_bit_sequencer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .tx_byte    (tx_byte),
        .ack_level  (ack_level),
        .line_bits  (line_bits),
        .line_ack   (line_ack),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .sample_now (sample_now),
        .last_event (last_event),
        .rx_byte    (rx_byte),
        .ack_seen   (ack_seen)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one command and hold it until the block takes it
    task automatic send_cmd(input logic [2:0] op, input logic [7:0] tx, input logic al,
                            input logic [7:0] lb, input logic la);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        tx_byte   <= tx;
        ack_level <= al;
        line_bits <= lb;
        line_ack  <= la;
        do
            @(posedge clk);
        while (!in_ready);
        sb.expand_command(op, tx, al, lb, la);
        if (op == OP_SPARE_A || op == OP_SPARE_B)
            ignored_cmds++;
        else
            sent_cmds++;
    endtask

    // Command with random values in all of its data fields
    task automatic send_plain(input logic [2:0] op);
        send_cmd(op, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Well-formed transfer: start, address, ack, data phase, stop
    task automatic bus_transfer();
        logic [7:0] addr;
        int         nbytes;
        addr = 8'($urandom);
        nbytes = $urandom_range(1, 4);
        send_plain(OP_START);
        send_cmd(OP_WRITE, addr, 1'($urandom), 8'($urandom), 1'($urandom));
        send_cmd(OP_RECV_ACK, 8'($urandom), 1'($urandom), 8'($urandom),
                 $urandom_range(0, 7) == 0);
        for (int i = 0; i < nbytes; i++)
        begin
            if (addr[0])
            begin
                send_cmd(OP_READ, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
                // master NACKs the final byte
                send_cmd(OP_SEND_ACK, 8'($urandom), i == nbytes - 1, 8'($urandom),
                         1'($urandom));
            end
            else
            begin
                send_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
                send_cmd(OP_RECV_ACK, 8'($urandom), 1'($urandom), 8'($urandom),
                         $urandom_range(0, 5) == 0);
            end
        end
        send_plain(OP_STOP);
        transfers++;
    endtask

    // Receiver: check accepted writes, stall in bursts, one long hold
    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_pin_write(scl_level, sda_level, sample_now, last_event,
                                   rx_byte, ack_seen);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && sent_cmds >= HOLD_AT_CMD)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(0, 17);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles", quiet);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command, dropped opcodes, repeated start
        send_plain(OP_START);
        send_cmd(OP_WRITE, 8'h00, 1'($urandom), 8'($urandom), 1'($urandom));
        send_cmd(OP_RECV_ACK, 8'($urandom), 1'($urandom), 8'($urandom), 1'b0);
        send_cmd(OP_WRITE, 8'hFF, 1'($urandom), 8'($urandom), 1'($urandom));
        send_cmd(OP_RECV_ACK, 8'($urandom), 1'($urandom), 8'($urandom), 1'b1);
        send_cmd(OP_WRITE, 8'hA5, 1'($urandom), 8'($urandom), 1'($urandom));
        send_cmd(OP_READ, 8'($urandom), 1'($urandom), 8'h00, 1'($urandom));
        send_cmd(OP_SEND_ACK, 8'($urandom), 1'b0, 8'($urandom), 1'($urandom));
        send_cmd(OP_READ, 8'($urandom), 1'($urandom), 8'hFF, 1'($urandom));
        send_cmd(OP_SEND_ACK, 8'($urandom), 1'b1, 8'($urandom), 1'($urandom));
        send_cmd(OP_READ, 8'($urandom), 1'($urandom), 8'h5A, 1'($urandom));
        send_cmd(OP_RECV_ACK, 8'($urandom), 1'($urandom), 8'($urandom), 1'b1);
        send_plain(OP_STOP);
        send_plain(OP_SPARE_A);
        send_plain(OP_SPARE_B);
        send_plain(OP_START);
        send_plain(OP_START);
        send_cmd(OP_WRITE, 8'h01, 1'($urandom), 8'($urandom), 1'($urandom));
        send_plain(OP_STOP);
        send_plain(OP_STOP);
        send_cmd(OP_SEND_ACK, 8'($urandom), 1'b1, 8'($urandom), 1'($urandom));

        // random: mostly transfers, some loose commands
        while (sent_cmds < TARGET_CMDS)
        begin
            if (sent_cmds >= QUIET_FROM_CMD)
            begin
                sender_idles = 1'b0;
                receiver_idles = 1'b0;
            end
            else
            begin
                sender_idles = $urandom_range(0, 4) != 0;
                receiver_idles = $urandom_range(0, 4) != 0;
            end
            if ($urandom_range(0, 6) != 0)
                bus_transfer();
            else
                repeat ($urandom_range(1, 3)) send_plain(3'($urandom_range(0, 7)));
        end
        in_valid <= 1'b0;

        // drain
        while (sb.pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands in %0d transfers plus %0d dropped opcodes;",
                 sent_cmds, transfers, ignored_cmds);
        $display("checked %0d pin writes under random stalls and one long receiver hold",
                 sb.writes_checked);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
